// File: sv/eeu_pkg.sv
package eeu_pkg;

   // Transaction modes
   typedef enum logic [1:0] {
      MODE_POST     = 2'd0,
      MODE_WITHDRAW = 2'd1,
      MODE_CHECK    = 2'd2,
      MODE_TAKE     = 2'd3
   } eeu_mode_type;

   localparam int unsigned NUM_LEVELS = 8;
   localparam int unsigned LEVEL_W    = 3;
   localparam int unsigned VEC_W      = 8;
   localparam int unsigned SR_W       = 16;
   localparam int unsigned ADDR_W     = 32;

   // Status register bit positions
   localparam int unsigned SR_T_POS  = 15;
   localparam int unsigned SR_S_POS  = 13;
   localparam int unsigned SR_M_POS  = 12;
   localparam int unsigned SR_I_LSB  = 8;
   localparam int unsigned SR_I_MSB  = 10;

   // Frame format nibble is 4 | SP[1:0]
   localparam logic [1:0] FRAME_FMT_HI = 2'b01;

   // Stack frame size in bytes
   localparam logic [ADDR_W-1:0] FRAME_BYTES = 32'd8;

   // Vectors 0..15 that push the faulting instruction's start address
   localparam logic [15:0] FAULT_PC_MASK = 16'b0100_1101_0001_1100;

   // Captured request
   typedef struct packed {
      eeu_mode_type        mode;
      logic [LEVEL_W-1:0]  level;
      logic [VEC_W-1:0]    vector;
      logic [SR_W-1:0]     status_reg;
      logic [ADDR_W-1:0]   program_counter;
      logic [ADDR_W-1:0]   instruction_start;
      logic [ADDR_W-1:0]   stack_pointer;
   } eeu_req_type;

   // Result
   typedef struct packed {
      logic                taken;
      logic [LEVEL_W-1:0]  taken_level;
      logic [VEC_W-1:0]    taken_vector;
      logic [ADDR_W-1:0]   frame_word;
      logic [ADDR_W-1:0]   pushed_pc;
      logic [ADDR_W-1:0]   new_stack_pointer;
      logic [SR_W-1:0]     new_status_reg;
      logic [ADDR_W-1:0]   handler_fetch_address;
      logic                withdraw_unset;
   } eeu_rsp_type;

endpackage

// File: sv/exception_entry_unit_core.sv
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  mode, level, vector, SR, PC, start, SP
// rsp_      out        rsp_valid/rsp_stall  taken .. withdraw_unset
// csr_      in         csr_wr_en            vector_base (32 bits)
//
// One transaction per cycle while no stall holds the flow; each request passes
// through the input register and then the result register.
// Pending levels and their vectors update as a transaction leaves the input
// register, so transactions act on state strictly in order.
// Synchronous reset clears pending levels, vector_base and both valid flags.
// A stalled result holds; the input register keeps accepting until it is full.
module exception_entry_unit_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_mode,
   input  logic [eeu_pkg::LEVEL_W-1:0]    req_level,
   input  logic [eeu_pkg::VEC_W-1:0]      req_vector,
   input  logic [eeu_pkg::SR_W-1:0]       req_status_reg,
   input  logic [eeu_pkg::ADDR_W-1:0]     req_program_counter,
   input  logic [eeu_pkg::ADDR_W-1:0]     req_instruction_start,
   input  logic [eeu_pkg::ADDR_W-1:0]     req_stack_pointer,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_taken,
   output logic [eeu_pkg::LEVEL_W-1:0]    rsp_taken_level,
   output logic [eeu_pkg::VEC_W-1:0]      rsp_taken_vector,
   output logic [eeu_pkg::ADDR_W-1:0]     rsp_frame_word,
   output logic [eeu_pkg::ADDR_W-1:0]     rsp_pushed_pc,
   output logic [eeu_pkg::ADDR_W-1:0]     rsp_new_stack_pointer,
   output logic [eeu_pkg::SR_W-1:0]       rsp_new_status_reg,
   output logic [eeu_pkg::ADDR_W-1:0]     rsp_handler_fetch_address,
   output logic                           rsp_withdraw_unset,
   input  logic                           csr_wr_en,
   input  logic [eeu_pkg::ADDR_W-1:0]     csr_wr_data
);
   import eeu_pkg::*;

   logic                      in_valid_ff, in_valid_in;
   eeu_req_type               in_req_ff;
   logic                      out_valid_ff, out_valid_in;
   eeu_rsp_type               out_rsp_ff, out_rsp_in;
   logic [ADDR_W-1:0]         vector_base_ff;
   logic [NUM_LEVELS-1:0]     pending_ff, pending_in;
   logic [VEC_W-1:0]          level_vectors_ff [NUM_LEVELS];

   logic                      req_accept;
   logic                      advance;
   logic [LEVEL_W-1:0]        mask;
   logic [NUM_LEVELS-1:0]     eligible;
   logic                      found;
   logic [LEVEL_W-1:0]        pick;
   logic [VEC_W-1:0]          ent_vec;
   logic                      ent_irq;
   logic                      ent_take;
   logic [SR_W-1:0]           ent_sr;

   // Handshake: input register moves on when the result register frees up
   assign advance    = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign in_valid_in  = req_accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // Input register and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         pending_ff     <= '0;
         vector_base_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         pending_ff   <= pending_in;
         if (csr_wr_en) begin
            vector_base_ff <= csr_wr_data;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_req_ff.mode              <= eeu_mode_type'(req_mode);
         in_req_ff.level             <= req_level;
         in_req_ff.vector            <= req_vector;
         in_req_ff.status_reg        <= req_status_reg;
         in_req_ff.program_counter   <= req_program_counter;
         in_req_ff.instruction_start <= req_instruction_start;
         in_req_ff.stack_pointer     <= req_stack_pointer;
      end
      if (advance) begin
         out_rsp_ff <= out_rsp_in;
      end
   end

   // Acknowledge vector store, written on post
   always_ff @(posedge clock) begin
      if (advance && in_req_ff.mode == MODE_POST) begin
         level_vectors_ff[in_req_ff.level] <= in_req_ff.vector;
      end
   end

   // Pending level update
   always_comb begin
      pending_in = pending_ff;
      if (advance) begin
         if (in_req_ff.mode == MODE_POST) begin
            pending_in[in_req_ff.level] = 1'b1;
         end else if (in_req_ff.mode == MODE_WITHDRAW) begin
            pending_in[in_req_ff.level] = 1'b0;
         end
      end
   end

   // Highest pending level above the SR mask
   assign mask = in_req_ff.status_reg[SR_I_MSB:SR_I_LSB];

   always_comb begin
      found = 1'b0;
      pick  = '0;
      for (int i = 0; i < NUM_LEVELS; i++) begin
         eligible[i] = pending_ff[i] && (LEVEL_W'(i) > mask);
         if (eligible[i]) begin
            found = 1'b1;
            pick  = LEVEL_W'(i);
         end
      end
   end

   // Exception entry
   assign ent_irq  = (in_req_ff.mode == MODE_CHECK);
   assign ent_take = (ent_irq && found) || (in_req_ff.mode == MODE_TAKE);
   assign ent_vec  = ent_irq ? level_vectors_ff[pick] : in_req_ff.vector;

   always_comb begin
      ent_sr = in_req_ff.status_reg;
      ent_sr[SR_S_POS] = 1'b1;
      ent_sr[SR_T_POS] = 1'b0;
      if (ent_irq) begin
         ent_sr[SR_M_POS] = 1'b0;
         ent_sr[SR_I_MSB:SR_I_LSB] = pick;
      end
   end

   always_comb begin
      out_rsp_in = '0;
      if (ent_take) begin
         out_rsp_in.taken        = 1'b1;
         out_rsp_in.taken_level  = ent_irq ? pick : '0;
         out_rsp_in.taken_vector = ent_vec;
         out_rsp_in.frame_word   = {FRAME_FMT_HI, in_req_ff.stack_pointer[1:0], 2'b00,
                                    ent_vec, 2'b00, in_req_ff.status_reg};
         out_rsp_in.pushed_pc    = (ent_vec[7:4] == 4'd0 && FAULT_PC_MASK[ent_vec[3:0]])
                                   ? in_req_ff.instruction_start
                                   : in_req_ff.program_counter;
         out_rsp_in.new_stack_pointer     = in_req_ff.stack_pointer - FRAME_BYTES;
         out_rsp_in.new_status_reg        = ent_sr;
         out_rsp_in.handler_fetch_address = vector_base_ff +
                                            {{(ADDR_W-VEC_W-2){1'b0}}, ent_vec, 2'b00};
      end
      if (in_req_ff.mode == MODE_WITHDRAW) begin
         out_rsp_in.withdraw_unset = !pending_ff[in_req_ff.level];
      end
   end

   // Result ports
   assign rsp_valid                 = out_valid_ff;
   assign rsp_taken                 = out_rsp_ff.taken;
   assign rsp_taken_level           = out_rsp_ff.taken_level;
   assign rsp_taken_vector          = out_rsp_ff.taken_vector;
   assign rsp_frame_word            = out_rsp_ff.frame_word;
   assign rsp_pushed_pc             = out_rsp_ff.pushed_pc;
   assign rsp_new_stack_pointer     = out_rsp_ff.new_stack_pointer;
   assign rsp_new_status_reg        = out_rsp_ff.new_status_reg;
   assign rsp_handler_fetch_address = out_rsp_ff.handler_fetch_address;
   assign rsp_withdraw_unset        = out_rsp_ff.withdraw_unset;

`ifndef ASSERT_OFF
   // A taken interrupt level always means a frame was produced
   a_level_implies_taken: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.taken_level != '0) |-> out_rsp_ff.taken)
      else $error("interrupt level reported without a frame");

   // Withdraw never produces a frame
   a_withdraw_no_frame: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.withdraw_unset) |-> !out_rsp_ff.taken)
      else $error("withdraw result carries a frame");

   // An interrupt taken sits above the old mask and becomes the new mask
   a_irq_mask: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_rsp_ff.taken_level != '0) |->
         (out_rsp_ff.new_status_reg[SR_I_MSB:SR_I_LSB] == out_rsp_ff.taken_level &&
          out_rsp_ff.frame_word[SR_I_MSB:SR_I_LSB] < out_rsp_ff.taken_level))
      else $error("interrupt mask update inconsistent");
`endif

endmodule

// File: tb/sv/tb.sv
module tb;
   import eeu_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PHASE_ITEMS    = 100;
   localparam int MAX_PRINTS     = 100;

   // One directed row; fixed rows carry a hand-computed result
   typedef struct {
      eeu_req_type txn;
      bit          fixed;
      eeu_rsp_type want;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [1:0]          req_mode = '0;
   logic [LEVEL_W-1:0]  req_level = '0;
   logic [VEC_W-1:0]    req_vector = '0;
   logic [SR_W-1:0]     req_status_reg = '0;
   logic [ADDR_W-1:0]   req_program_counter = '0;
   logic [ADDR_W-1:0]   req_instruction_start = '0;
   logic [ADDR_W-1:0]   req_stack_pointer = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic                rsp_taken;
   logic [LEVEL_W-1:0]  rsp_taken_level;
   logic [VEC_W-1:0]    rsp_taken_vector;
   logic [ADDR_W-1:0]   rsp_frame_word;
   logic [ADDR_W-1:0]   rsp_pushed_pc;
   logic [ADDR_W-1:0]   rsp_new_stack_pointer;
   logic [SR_W-1:0]     rsp_new_status_reg;
   logic [ADDR_W-1:0]   rsp_handler_fetch_address;
   logic                rsp_withdraw_unset;
   logic                csr_wr_en = 1'b0;
   logic [ADDR_W-1:0]   csr_wr_data = '0;

   // Predictor copy of the block state
   logic [ADDR_W-1:0]     table_base = '0;
   logic [NUM_LEVELS-1:0] pending_mask = '0;
   logic [VEC_W-1:0]      ack_vector [NUM_LEVELS];

   eeu_rsp_type  frames_due [$];
   stim_row_type directed_rows [$];
   int           errors = 0;
   int           rsp_count = 0;
   int           quiet_cycles = 0;
   int           stall_left = 0;
   bit           calm = 1'b0;

   exception_entry_unit_core i_dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_mode                  (req_mode),
      .req_level                 (req_level),
      .req_vector                (req_vector),
      .req_status_reg            (req_status_reg),
      .req_program_counter       (req_program_counter),
      .req_instruction_start     (req_instruction_start),
      .req_stack_pointer         (req_stack_pointer),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_taken                 (rsp_taken),
      .rsp_taken_level           (rsp_taken_level),
      .rsp_taken_vector          (rsp_taken_vector),
      .rsp_frame_word            (rsp_frame_word),
      .rsp_pushed_pc             (rsp_pushed_pc),
      .rsp_new_stack_pointer     (rsp_new_stack_pointer),
      .rsp_new_status_reg        (rsp_new_status_reg),
      .rsp_handler_fetch_address (rsp_handler_fetch_address),
      .rsp_withdraw_unset        (rsp_withdraw_unset),
      .csr_wr_en                 (csr_wr_en),
      .csr_wr_data               (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Exception frame, new SR and handler address for one taken vector
   function automatic eeu_rsp_type build_frame(eeu_req_type t, logic [VEC_W-1:0] vec,
                                               logic [LEVEL_W-1:0] lvl, bit irq);
      eeu_rsp_type     r;
      logic [SR_W-1:0] sr;
      r = '0;
      r.taken        = 1'b1;
      r.taken_level  = irq ? lvl : '0;
      r.taken_vector = vec;
      r.frame_word   = {2'b01, t.stack_pointer[1:0], 2'b00, vec, 2'b00, t.status_reg};
      // bus and address errors, illegal, privilege, traps and format errors push the start
      r.pushed_pc    = (vec inside {8'd2, 8'd3, 8'd4, 8'd8, 8'd10, 8'd11, 8'd14})
                       ? t.instruction_start : t.program_counter;
      r.new_stack_pointer = t.stack_pointer - 32'd8;
      sr = t.status_reg;
      sr[SR_S_POS] = 1'b1;
      sr[SR_T_POS] = 1'b0;
      if (irq) begin
         sr[SR_M_POS] = 1'b0;
         sr[SR_I_MSB:SR_I_LSB] = lvl;
      end
      r.new_status_reg        = sr;
      r.handler_fetch_address = table_base + {22'd0, vec, 2'b00};
      return r;
   endfunction

   // Expected result of one transaction; updates the pending state
   function automatic eeu_rsp_type predict_entry(eeu_req_type t);
      eeu_rsp_type        r;
      logic [LEVEL_W-1:0] mask;
      int                 lv;
      r = '0;
      mask = t.status_reg[SR_I_MSB:SR_I_LSB];
      case (t.mode)
         MODE_POST: begin
            pending_mask[t.level] = 1'b1;
            ack_vector[t.level]   = t.vector;
         end
         MODE_WITHDRAW: begin
            r.withdraw_unset = !pending_mask[t.level];
            pending_mask[t.level] = 1'b0;
         end
         MODE_CHECK: begin
            // highest pending level strictly above the mask
            for (lv = NUM_LEVELS - 1; lv > int'(mask); lv--) begin
               if (pending_mask[lv]) begin
                  r = build_frame(t, ack_vector[lv], LEVEL_W'(lv), 1'b1);
                  break;
               end
            end
         end
         default: r = build_frame(t, t.vector, '0, 1'b0);
      endcase
      return r;
   endfunction

   function automatic eeu_req_type txn_of(eeu_mode_type m, logic [LEVEL_W-1:0] lvl,
                                          logic [VEC_W-1:0] vec, logic [SR_W-1:0] sr,
                                          logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] start,
                                          logic [ADDR_W-1:0] sp);
      eeu_req_type t;
      t.mode              = m;
      t.level             = lvl;
      t.vector            = vec;
      t.status_reg        = sr;
      t.program_counter   = pc;
      t.instruction_start = start;
      t.stack_pointer     = sp;
      return t;
   endfunction

   task automatic add_row(eeu_req_type t, bit fixed, eeu_rsp_type want);
      stim_row_type row;
      row.txn   = t;
      row.fixed = fixed;
      row.want  = want;
      directed_rows.push_back(row);
   endtask

   task automatic report_mismatch(string msg);
      errors++;
      if (errors <= MAX_PRINTS)
         $display("mismatch at result %0d: %s", rsp_count, msg);
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   // Drive one transaction and hold it until accepted
   task automatic send_txn(eeu_req_type t, bit fixed, eeu_rsp_type want);
      eeu_rsp_type pred;
      req_valid             <= 1'b1;
      req_mode              <= t.mode;
      req_level             <= t.level;
      req_vector            <= t.vector;
      req_status_reg        <= t.status_reg;
      req_program_counter   <= t.program_counter;
      req_instruction_start <= t.instruction_start;
      req_stack_pointer     <= t.stack_pointer;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      pred = predict_entry(t);
      frames_due.push_back(fixed ? want : pred);
   endtask

   // Random sender gap
   task automatic sender_gap();
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
   endtask

   // Sender idles until every result is back
   task automatic drain_results();
      req_valid <= 1'b0;
      while (frames_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Result checking, watchdog and receiver stall bursts
   always @(posedge clock) begin
      eeu_rsp_type got;
      eeu_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            rsp_count++;
            got = {rsp_taken, rsp_taken_level, rsp_taken_vector, rsp_frame_word,
                   rsp_pushed_pc, rsp_new_stack_pointer, rsp_new_status_reg,
                   rsp_handler_fetch_address, rsp_withdraw_unset};
            if (frames_due.size() == 0) begin
               report_mismatch("result with no transaction pending");
            end else begin
               want = frames_due.pop_front();
               check_field("taken", 32'(got.taken), 32'(want.taken));
               check_field("taken_level", 32'(got.taken_level), 32'(want.taken_level));
               check_field("taken_vector", 32'(got.taken_vector), 32'(want.taken_vector));
               check_field("frame_word", got.frame_word, want.frame_word);
               check_field("pushed_pc", got.pushed_pc, want.pushed_pc);
               check_field("new_stack_pointer", got.new_stack_pointer,
                           want.new_stack_pointer);
               check_field("new_status_reg", 32'(got.new_status_reg),
                           32'(want.new_status_reg));
               check_field("handler_fetch_address", got.handler_fetch_address,
                           want.handler_fetch_address);
               check_field("withdraw_unset", 32'(got.withdraw_unset),
                           32'(want.withdraw_unset));
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 17);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus
   initial begin
      logic [ADDR_W-1:0] base_set [5];
      eeu_req_type       t;
      eeu_mode_type      m;
      logic [SR_W-1:0]   sr;
      logic [VEC_W-1:0]  vec;
      int                pick;

      base_set = '{32'hFFFF_FFFF, 32'hFFFF_FC00, 32'h0, 32'h0000_0004, 32'h0000_0000};
      base_set[2] = $urandom();

      // after reset nothing is pending; fixed rows at reset base
      add_row(txn_of(MODE_WITHDRAW, 3'd3, 8'h00, 16'h0000, 32'h0, 32'h0, 32'h0), 1'b1,
              '{taken: 1'b0, taken_level: 3'd0, taken_vector: 8'h00, frame_word: 32'h0,
                pushed_pc: 32'h0, new_stack_pointer: 32'h0, new_status_reg: 16'h0,
                handler_fetch_address: 32'h0, withdraw_unset: 1'b1});
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h0000, 32'h0, 32'h0, 32'h0), 1'b1, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'h00, 16'h0000, 32'h1000, 32'h2000, 32'h0), 1'b1,
              '{taken: 1'b1, taken_level: 3'd0, taken_vector: 8'h00,
                frame_word: 32'h4000_0000, pushed_pc: 32'h1000,
                new_stack_pointer: 32'hFFFF_FFF8, new_status_reg: 16'h2000,
                handler_fetch_address: 32'h0, withdraw_unset: 1'b0});
      add_row(txn_of(MODE_TAKE, 3'd7, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF, 32'h0,
                     32'hFFFF_FFFF), 1'b1,
              '{taken: 1'b1, taken_level: 3'd0, taken_vector: 8'hFF,
                frame_word: 32'h73FC_FFFF, pushed_pc: 32'hFFFF_FFFF,
                new_stack_pointer: 32'hFFFF_FFF7, new_status_reg: 16'h7FFF,
                handler_fetch_address: 32'h0000_03FC, withdraw_unset: 1'b0});
      // vectors that push the instruction start, and neighbors that do not
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd1, 16'h8000, 32'hA000_0000, 32'hB000_0000,
                     32'h0000_0002), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd2, 16'h8000, 32'hA000_0004, 32'hB000_0004,
                     32'h0000_0001), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd3, 16'h1700, 32'hA000_0008, 32'hB000_0008,
                     32'h0000_0003), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd4, 16'h0000, 32'h1, 32'h2, 32'h8), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd8, 16'h2000, 32'h3, 32'h4, 32'h7), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd10, 16'h0500, 32'h5, 32'h6, 32'h4), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd11, 16'h0300, 32'h7, 32'h8, 32'h5), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd14, 16'h0100, 32'h9, 32'hA, 32'h6), 1'b0, '0);
      add_row(txn_of(MODE_TAKE, 3'd0, 8'd15, 16'h0200, 32'hB, 32'hC, 32'hE), 1'b0, '0);
      // level zero can be posted but is never taken
      add_row(txn_of(MODE_POST, 3'd0, 8'h40, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h0000, 32'h10, 32'h20, 32'h30), 1'b0, '0);
      // level seven: masked at mask seven, taken below it
      add_row(txn_of(MODE_POST, 3'd7, 8'hFF, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h2700, 32'h10, 32'h20, 32'h30), 1'b0, '0);
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h9600, 32'h44, 32'h55, 32'h66), 1'b0, '0);
      // repeated post overwrites the stored vector
      add_row(txn_of(MODE_POST, 3'd3, 8'h41, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_POST, 3'd3, 8'h42, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_WITHDRAW, 3'd7, 8'h00, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h1000, 32'h77, 32'h88, 32'h99), 1'b0, '0);
      // withdraw of a level no longer pending, then of levels still pending
      add_row(txn_of(MODE_WITHDRAW, 3'd7, 8'h00, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_WITHDRAW, 3'd0, 8'h00, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_WITHDRAW, 3'd3, 8'h00, 16'h0, 32'h0, 32'h0, 32'h0), 1'b0, '0);
      add_row(txn_of(MODE_CHECK, 3'd0, 8'h00, 16'h0000, 32'h1, 32'h2, 32'h3), 1'b0, '0);

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      foreach (directed_rows[i]) begin
         sender_gap();
         send_txn(directed_rows[i].txn, directed_rows[i].fixed, directed_rows[i].want);
      end

      // random phases, one vector_base setting each
      foreach (base_set[p]) begin
         drain_results();
         csr_wr_en   <= 1'b1;
         csr_wr_data <= base_set[p];
         @(posedge clock);
         csr_wr_en   <= 1'b0;
         table_base   = base_set[p];
         calm         = (p == 4);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0, 1, 2: m = MODE_POST;
               3, 4:    m = MODE_WITHDRAW;
               5, 6, 7: m = MODE_CHECK;
               default: m = MODE_TAKE;
            endcase
            sr = SR_W'($urandom_range(0, 16'hFFFF));
            // bias the mask low so checks often find a level
            if ($urandom_range(0, 1) == 1)
               sr[SR_I_MSB:SR_I_LSB] = LEVEL_W'($urandom_range(0, 3));
            vec = ($urandom_range(0, 1) == 1) ? VEC_W'($urandom_range(0, 15))
                                               : VEC_W'($urandom_range(0, 255));
            t = txn_of(m, LEVEL_W'($urandom_range(0, 7)), vec, sr, $urandom(), $urandom(),
                       $urandom());
            sender_gap();
            send_txn(t, 1'b0, '0);
         end
      end

      drain_results();
      if (errors == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
